/* hdl/edf_pkg.sv */
`default_nettype none

package edf_pkg;

  // Ring geometry
  localparam int RingDepth = 8;
  localparam int SlotW     = (RingDepth > 1) ? $clog2(RingDepth) : 1;
  localparam int CntW      = $clog2(RingDepth + 1);

  // Distance path widths
  localparam int EchoW  = 15;
  localparam int TimeW  = 32;
  localparam int DistW  = 18;
  localparam int CfgW   = 10;
  localparam int ScaleW = 13;
  localparam int ProdW  = EchoW + ScaleW;
  localparam int ShiftW = 10;
  localparam int SumW   = DistW + $clog2(RingDepth);
  localparam int StepW  = $clog2(SumW);

  // Conversion and filter constants
  localparam logic [ScaleW-1:0] EchoScale = 13'd4496;   // 0.0343/2 cm per us, times 256*1024
  localparam logic [TimeW-1:0]  WindowMs  = 32'd3000;
  localparam logic [DistW-1:0]  NearLimit = 18'd7680;   // 30 cm
  localparam logic [DistW-1:0]  StepLimit = 18'd512;    // 2 cm

  // Register map (index = byte address / 4)
  localparam logic RegMinIdx = 1'b0;
  localparam logic RegMaxIdx = 1'b1;
  localparam logic [CfgW-1:0] MinReset = 10'd0;
  localparam logic [CfgW-1:0] MaxReset = 10'd1023;

  typedef enum logic [2:0] {
    OUT_RATE_LIMITED = 3'd0,
    OUT_TOO_CLOSE    = 3'd1,
    OUT_OUT_OF_RANGE = 3'd2,
    OUT_KEPT         = 3'd3,
    OUT_UPDATED      = 3'd4
  } outcome_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CALC,
    ST_CHECK,
    ST_SUM,
    ST_DIV,
    ST_DONE
  } state_e;

endpackage

`default_nettype wire

/* hdl/edf_if.sv */
`default_nettype none

// Input channel: one echo reading per beat
interface edf_in_if;
  import edf_pkg::*;

  logic             valid;
  logic             ready;
  logic [EchoW-1:0] echo_us;
  logic [TimeW-1:0] now_ms;

  modport source (output valid, output echo_us, output now_ms, input ready);
  modport sink   (input valid, input echo_us, input now_ms, output ready);
endinterface

// Output channel: held distance and outcome code per beat
interface edf_out_if;
  import edf_pkg::*;

  logic             valid;
  logic             ready;
  logic [DistW-1:0] held_distance;
  logic [2:0]       outcome;

  modport source (output valid, output held_distance, output outcome, input ready);
  modport sink   (input valid, input held_distance, input outcome, output ready);
endinterface

`default_nettype wire

/* hdl/echo_distance_filter.sv */
// Echo distance filter.
// Input channel in_i carries one reading per beat: echo_us (pulse width in us)
// and now_ms (wrapping millisecond time). Output channel out_o returns exactly
// one beat per reading: held_distance (1/256 cm) and an outcome code.
// The APB port sets min_distance_cm (address 0) and max_distance_cm (address 4);
// write it only while no reading is in flight.
// A reading that is rate limited, too close or out of range goes from the
// check straight to the output step. An accepted reading is stored in an
// 8-entry ring memory, the filled entries are summed one per cycle through
// the single read port, and the sum is divided by the fill count N with a
// one-bit-per-cycle divider of 21 steps. One reading is processed at a time;
// the next one is taken the cycle after the beat loads.
// Results go to an output register; the next reading is accepted while a beat
// waits there, and processing holds at its final step until the receiver
// takes the earlier beat.
// Reset clears the held distance, the update time, the ring fill state and the
// registers (min 0, max 1023); ring contents need no clearing, since only
// entries already written are summed.
`default_nettype none

module echo_distance_filter (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  edf_in_if.sink           in_i,
  edf_out_if.source        out_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);
  import edf_pkg::*;

  // Configuration registers
  logic [CfgW-1:0] min_cm_q, max_cm_q;
  logic            cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_cm_q <= MinReset;
      max_cm_q <= MaxReset;
    end else if (cfg_we) begin
      case (paddr[2])
        RegMinIdx: min_cm_q <= pwdata[CfgW-1:0];
        RegMaxIdx: max_cm_q <= pwdata[CfgW-1:0];
        default:   ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      RegMinIdx: prdata = {{(32-CfgW){1'b0}}, min_cm_q};
      RegMaxIdx: prdata = {{(32-CfgW){1'b0}}, max_cm_q};
      default:   prdata = '0;
    endcase
  end

  // State and control signals
  state_e           state_q, state_d;
  logic             in_accept;
  logic             mem_we;
  logic             div_start;
  logic             out_load;
  logic             out_free;
  logic             sum_done;
  logic             div_done;
  logic             reading_ok;

  logic [EchoW-1:0] echo_q;
  logic [TimeW-1:0] now_q;
  logic [DistW-1:0] dist_q;
  logic             late_q;
  outcome_e         outcome_q;

  logic [SlotW-1:0] slot_q;
  logic             full_q;
  logic [DistW-1:0] filt_q;
  logic [TimeW-1:0] last_q;

  logic [CntW-1:0]  idx_q;
  logic             rd_pend_q;
  logic [SumW-1:0]  acc_q;
  logic [CntW-1:0]  count;
  logic [SumW-1:0]  quotient;
  logic [DistW-1:0] avg_q;

  logic [ProdW-1:0] prod;
  logic [DistW-1:0] min_dist, max_dist;
  logic [DistW-1:0] abs_diff;
  logic             do_update;
  outcome_e         final_outcome;

  logic             out_valid_q;
  logic [DistW-1:0] out_held_q;
  outcome_e         out_code_q;

  // Ring memory
  logic [DistW-1:0] ring_mem [RingDepth];
  logic [DistW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      ring_mem[slot_q] <= dist_q;
    end
    rd_data_q <= ring_mem[idx_q[SlotW-1:0]];
  end

  // Shared conditions
  assign in_accept  = in_i.valid && in_i.ready;
  assign out_free   = !out_valid_q || out_o.ready;
  assign count      = full_q ? CntW'(RingDepth) : CntW'(slot_q);
  assign sum_done   = (idx_q == count) && !rd_pend_q;
  assign prod       = ProdW'(echo_q) * ProdW'(EchoScale);
  assign min_dist   = {min_cm_q, 8'd0};
  assign max_dist   = {max_cm_q, 8'd0};
  assign reading_ok = late_q && (dist_q > NearLimit) &&
                      !(dist_q < min_dist || dist_q > max_dist);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (in_i.valid) state_d = ST_CALC;
      ST_CALC:  state_d = ST_CHECK;
      ST_CHECK: state_d = reading_ok ? ST_SUM : ST_DONE;
      ST_SUM:   if (sum_done) state_d = ST_DIV;
      ST_DIV:   if (div_done) state_d = ST_DONE;
      ST_DONE:  if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    in_i.ready = 1'b0;
    mem_we     = 1'b0;
    div_start  = 1'b0;
    out_load   = 1'b0;
    case (state_q)
      ST_IDLE:  in_i.ready = 1'b1;
      ST_CHECK: mem_we     = reading_ok;
      ST_SUM:   div_start  = sum_done;
      ST_DONE:  out_load   = out_free;
      default:  ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Capture, convert and classify the reading
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      echo_q <= in_i.echo_us;
      now_q  <= in_i.now_ms;
    end
    if (state_q == ST_CALC) begin
      dist_q <= prod[ProdW-1:ShiftW];
      late_q <= ((now_q - last_q) >= WindowMs);
    end
    if (state_q == ST_CHECK) begin
      if (!late_q) begin
        outcome_q <= OUT_RATE_LIMITED;
      end else if (dist_q <= NearLimit) begin
        outcome_q <= OUT_TOO_CLOSE;
      end else if (!reading_ok) begin
        outcome_q <= OUT_OUT_OF_RANGE;
      end else begin
        outcome_q <= OUT_KEPT;
      end
    end
  end

  // Ring write pointer and fill flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
      full_q <= 1'b0;
    end else if (mem_we) begin
      if (slot_q == SlotW'(RingDepth - 1)) begin
        slot_q <= '0;
        full_q <= 1'b1;
      end else begin
        slot_q <= slot_q + 1'b1;
      end
    end
  end

  // Summing walk: one read issued per cycle, its data accumulated in the next cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q     <= '0;
      rd_pend_q <= 1'b0;
    end else if (state_q == ST_CHECK) begin
      idx_q     <= '0;
      rd_pend_q <= 1'b0;
    end else if (state_q == ST_SUM) begin
      rd_pend_q <= (idx_q != count);
      if (idx_q != count) begin
        idx_q <= idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_CHECK) begin
      acc_q <= '0;
    end else if (state_q == ST_SUM && rd_pend_q) begin
      acc_q <= acc_q + SumW'(rd_data_q);
    end
    if (div_done) begin
      avg_q <= quotient[DistW-1:0];
    end
  end

  edf_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (acc_q),
    .divisor_i  (count),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  // Hold decision
  always_comb begin
    abs_diff      = (avg_q >= filt_q) ? (avg_q - filt_q) : (filt_q - avg_q);
    do_update     = (outcome_q == OUT_KEPT) &&
                    ((filt_q == '0) || (abs_diff >= StepLimit));
    final_outcome = do_update ? OUT_UPDATED : outcome_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filt_q <= '0;
      last_q <= '0;
    end else if (out_load && do_update) begin
      filt_q <= avg_q;
      last_q <= now_q;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_held_q <= do_update ? avg_q : filt_q;
      out_code_q <= final_outcome;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.held_distance = out_held_q;
  assign out_o.outcome       = out_code_q;

`ifndef SYNTHESIS
  // The walk only runs with at least one filled entry
  a_sum_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SUM) |-> (count != '0))
    else $error("ring summed with no filled entries");

  // The held distance moves only when an updated beat is loaded
  a_filt_on_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (filt_q != $past(filt_q)) |-> ($past(out_load) && $past(do_update)))
    else $error("held distance changed outside an update");

  // Write pointer stays inside the ring
  a_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (slot_q <= SlotW'(RingDepth - 1)))
    else $error("ring write slot out of range");
`endif

endmodule

`default_nettype wire

/* hdl/edf_div.sv */
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module edf_div (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start_i,
  input  wire logic [edf_pkg::SumW-1:0] dividend_i,
  input  wire logic [edf_pkg::CntW-1:0] divisor_i,
  output logic                          done_o,
  output logic [edf_pkg::SumW-1:0]      quotient_o
);
  import edf_pkg::*;

  logic             busy_q;
  logic             done_q;
  logic [StepW-1:0] step_q;
  logic [CntW-1:0]  rem_q, rem_d;
  logic [SumW-1:0]  quo_q, quo_d;
  logic [CntW:0]    trial;
  logic             qbit;

  // One shift-subtract step
  always_comb begin
    trial = {rem_q, quo_q[SumW-1]};
    qbit  = (trial >= {1'b0, divisor_i});
    rem_d = qbit ? CntW'(trial - {1'b0, divisor_i}) : trial[CntW-1:0];
    quo_d = {quo_q[SumW-2:0], qbit};
  end

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      step_q <= StepW'(SumW - 1);
    end else if (busy_q) begin
      if (step_q == '0) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end else begin
        step_q <= step_q - 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

/* sim/echo_distance_checker.sv */
`timescale 1ns / 100ps

// Watches both channels and the register port, predicts the held distance and
// outcome for every reading, and compares each result beat in order.
module echo_distance_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  edf_in_if           in_mon,
  edf_out_if          out_mon,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output int          pending_o,
  output int unsigned fail_count_o
);
  import edf_pkg::*;

  typedef struct packed {
    logic [DistW-1:0] held;
    outcome_e         verdict;
  } distance_beat_t;

  localparam int unsigned PrintCap = 20;

  // Shadow of the filter state and limits
  logic [DistW-1:0] ring_q [RingDepth];
  int unsigned      slot_q;
  logic             ring_full_q;
  logic [DistW-1:0] held_q;
  logic [TimeW-1:0] last_update_q;
  logic [CfgW-1:0]  min_cm_q;
  logic [CfgW-1:0]  max_cm_q;

  distance_beat_t beats_due_q[$];
  int unsigned    mismatch_count = 0;

  assign fail_count_o = mismatch_count;

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    if (mismatch_count < PrintCap)
      $display("%0t mismatch: %s got %0d expected %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  // Next held distance and outcome for one reading; updates the shadow state
  task automatic filter_reading(input logic [EchoW-1:0] echo,
                                input logic [TimeW-1:0] stamp);
    logic [TimeW-1:0] since;
    int unsigned      reading_units;
    int unsigned      fill;
    int unsigned      total;
    int unsigned      avg;
    int unsigned      gap;
    int unsigned      idx;
    distance_beat_t   beat;
    since        = stamp - last_update_q;
    beat.verdict = OUT_RATE_LIMITED;
    if (since >= WindowMs) begin
      reading_units = (32'(echo) * 32'(EchoScale)) >> ShiftW;
      if (reading_units <= 32'(NearLimit)) begin
        beat.verdict = OUT_TOO_CLOSE;
      end else if (reading_units < (32'(min_cm_q) << 8) ||
                   reading_units > (32'(max_cm_q) << 8)) begin
        beat.verdict = OUT_OUT_OF_RANGE;
      end else begin
        ring_q[slot_q] = reading_units[DistW-1:0];
        if (slot_q == RingDepth - 1) begin
          slot_q      = 0;
          ring_full_q = 1'b1;
        end else begin
          slot_q++;
        end
        fill  = ring_full_q ? RingDepth : slot_q;
        total = 0;
        for (idx = 0; idx < fill; idx++) total += ring_q[idx];
        avg = total / fill;
        gap = (avg >= held_q) ? avg - held_q : held_q - avg;
        if (held_q == '0 || gap >= 32'(StepLimit)) begin
          held_q        = avg[DistW-1:0];
          last_update_q = stamp;
          beat.verdict  = OUT_UPDATED;
        end else begin
          beat.verdict = OUT_KEPT;
        end
      end
    end
    beat.held = held_q;
    beats_due_q.push_back(beat);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    distance_beat_t want;
    if (!rst_ni) begin
      slot_q        = 0;
      ring_full_q   = 1'b0;
      held_q        = '0;
      last_update_q = '0;
      min_cm_q      = MinReset;
      max_cm_q      = MaxReset;
      beats_due_q.delete();
    end else begin
      // register writes
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == RegMinIdx) min_cm_q = pwdata[CfgW-1:0];
        else max_cm_q = pwdata[CfgW-1:0];
      end
      // result beat against the oldest prediction
      if (out_mon.valid && out_mon.ready) begin
        if (beats_due_q.size() == 0) begin
          report_mismatch("result beat with nothing due, outcome", out_mon.outcome, 0);
        end else begin
          want = beats_due_q.pop_front();
          if (out_mon.held_distance !== want.held)
            report_mismatch("held_distance", out_mon.held_distance, want.held);
          if (out_mon.outcome !== want.verdict)
            report_mismatch("outcome", out_mon.outcome, want.verdict);
        end
      end
      // reading beat
      if (in_mon.valid && in_mon.ready) filter_reading(in_mon.echo_us, in_mon.now_ms);
    end
    pending_o = beats_due_q.size();
  end

endmodule

/* sim/echo_distance_filter_tb.sv */
`timescale 1ns / 100ps

// Drives readings in bursts and register settings between phases; the
// checker beside the block predicts and compares every result beat.
module echo_distance_filter_tb;
  import edf_pkg::*;

  localparam int unsigned HoldOffCycles = 400;
  localparam int unsigned StallLimit    = 4000;
  localparam int unsigned SettleCycles  = 8;
  localparam int unsigned TailCycles    = 60;

  // receiver stall styles
  localparam int unsigned ReadyAlways      = 0;
  localparam int unsigned ReadyCoin        = 1;
  localparam int unsigned ReadyEveryFourth = 2;
  localparam int unsigned ReadyMostly      = 3;

  logic        clk_i  = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int          pending;
  int unsigned fail_count;
  int unsigned burst_left = 0;
  bit          hold_off_req = 1'b0;
  logic [TimeW-1:0] clock_ms;

  edf_in_if  in_ch ();
  edf_out_if out_ch ();

  echo_distance_filter dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_ch),
    .out_o   (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  echo_distance_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_mon       (in_ch),
    .out_mon      (out_ch),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .pready       (pready),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .pending_o    (pending),
    .fail_count_o (fail_count)
  );

  always #2 clk_i = ~clk_i;

  // One reading beat; opens a new burst with a random gap when the last ran out
  task automatic offer_reading(input logic [EchoW-1:0] echo, input logic [TimeW-1:0] stamp);
    int unsigned pause;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      pause      = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 10);
      if (pause != 0) begin
        in_ch.valid <= 1'b0;
        repeat (pause) @(posedge clk_i);
      end
    end
    burst_left--;
    in_ch.valid   <= 1'b1;
    in_ch.echo_us <= echo;
    in_ch.now_ms  <= stamp;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  // Stop offering and wait until every predicted beat has come back
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_register(input logic idx, input logic [CfgW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= 32'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
  endtask

  task automatic apply_limits(input logic [CfgW-1:0] lo_cm, input logic [CfgW-1:0] hi_cm);
    drain_results();
    write_register(RegMinIdx, lo_cm);
    write_register(RegMaxIdx, hi_cm);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Main stimulus and verdict
  initial begin : stimulus
    int          phase;
    int          items;
    int          lo_cm;
    int          hi_cm;
    int          lo_echo;
    int          hi_echo;
    int          target_echo;
    int          echo_pick;
    int unsigned roll;
    in_ch.valid   <= 1'b0;
    in_ch.echo_us <= '0;
    in_ch.now_ms  <= '0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // window right after reset: last update counts as time zero
    offer_reading(15'd5000, 32'd0);
    offer_reading(15'd5000, 32'd2999);
    // timeout echo, then both sides of the 30 cm floor
    offer_reading(15'd0, 32'd3000);
    offer_reading(15'd1749, 32'd3001);
    offer_reading(15'd1750, 32'd3002);     // first update from zero
    offer_reading(15'd1800, 32'd3003);     // inside the fresh window
    offer_reading(15'h7FFF, 32'd6002);     // widest echo, beyond 30000 us
    offer_reading(15'd30000, 32'd9002);
    // millisecond counter wrapping through zero
    offer_reading(15'd30000, 32'hFFFF_FFFF);
    offer_reading(15'd30000, 32'h0000_0100);
    offer_reading(15'd30000, 32'd2999);
    // run the ring past its depth
    clock_ms = 32'd2999;
    repeat (5) begin
      clock_ms += 3000;
      offer_reading(15'd30000, clock_ms);
    end

    // 100..200 cm: echoes just outside and just inside each bound
    apply_limits(10'd100, 10'd200);
    clock_ms += 3000;
    offer_reading(15'd5830, clock_ms);
    clock_ms += 3000;
    offer_reading(15'd5831, clock_ms);
    clock_ms += 3000;
    offer_reading(15'd11661, clock_ms);
    clock_ms += 3000;
    offer_reading(15'd11662, clock_ms);

    // minimum above maximum
    apply_limits(10'd1023, 10'd0);
    clock_ms += 3000;
    offer_reading(15'd8746, clock_ms);
    clock_ms += 3000;
    offer_reading(15'h7FFF, clock_ms);

    // random phases, each under its own limits
    for (phase = 0; phase < 8; phase++) begin
      case (phase)
        0: begin lo_cm = 0;    hi_cm = 1023; items = 200; end
        1: begin lo_cm = 1023; hi_cm = 0;    items = 40;  end
        2: begin lo_cm = 0;    hi_cm = 0;    items = 40;  end
        3: begin lo_cm = 1023; hi_cm = 1023; items = 40;  end
        default: begin
          lo_cm = $urandom_range(0, 200);
          hi_cm = $urandom_range(lo_cm + 60, 1023);
          items = 220;
        end
      endcase
      apply_limits(CfgW'(lo_cm), CfgW'(hi_cm));
      if (phase == 0) hold_off_req = 1'b1;

      // echo span that lands roughly inside the limits
      lo_echo = (lo_cm * 58 > 1750) ? lo_cm * 58 : 1750;
      hi_echo = (hi_cm * 59 + 58 < 30000) ? hi_cm * 59 + 58 : 30000;
      if (lo_echo > hi_echo) begin
        lo_echo = 1750;
        hi_echo = 30000;
      end
      target_echo = $urandom_range(lo_echo, hi_echo);

      repeat (items) begin
        if ($urandom_range(0, 39) == 0) target_echo = $urandom_range(lo_echo, hi_echo);
        roll = $urandom_range(0, 99);
        if (roll < 72) begin
          // steady target with jitter; mostly past the window
          echo_pick = target_echo + int'($urandom_range(0, 240)) - 120;
          if (echo_pick > 32767) echo_pick = 32767;
          roll = $urandom_range(0, 99);
          if (roll < 60) clock_ms += $urandom_range(3000, 5000);
          else if (roll < 88) clock_ms += $urandom_range(0, 2999);
          else clock_ms += $urandom();
        end else if (roll < 80) begin
          // around the 30 cm floor
          echo_pick = $urandom_range(1740, 1760);
          clock_ms += $urandom_range(3000, 4000);
        end else begin
          echo_pick = $urandom_range(0, 32767);
          clock_ms  = $urandom();
        end
        offer_reading(EchoW'(echo_pick), clock_ms);
      end
    end

    drain_results();
    repeat (TailCycles) @(posedge clk_i);
    if (fail_count == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  // Result side: stretches of different stall styles, one long hold-off
  initial begin : result_drain
    int unsigned span;
    int unsigned style;
    int unsigned tick;
    bit          hold_off_done;
    hold_off_done = 1'b0;
    out_ch.ready <= 1'b0;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_off_req && !hold_off_done) begin
        // block fills up and stalls the reading side meanwhile
        out_ch.ready <= 1'b0;
        repeat (HoldOffCycles) @(posedge clk_i);
        hold_off_done = 1'b1;
      end
      span  = $urandom_range(20, 200);
      style = $urandom_range(ReadyAlways, ReadyMostly);
      for (tick = 0; tick < span; tick++) begin
        case (style)
          ReadyAlways:      out_ch.ready <= 1'b1;
          ReadyCoin:        out_ch.ready <= 1'($urandom_range(0, 1));
          ReadyEveryFourth: out_ch.ready <= (tick % 4 == 0);
          default:          out_ch.ready <= ($urandom_range(0, 3) != 0);
        endcase
        @(posedge clk_i);
      end
    end
  end

  // Ends the run when no beat moves on either channel for too long
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    @(posedge rst_ni);
    while (quiet < StallLimit) begin
      @(posedge clk_i);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("DONE: errors detected");
    $finish;
  end

endmodule
